// ===== src/mvt_pkg.sv =====
package mvt_pkg;

    // coordinate width used inside the datapath
    localparam int MVT_COORD_WIDTH = 32;

    // port field widths
    localparam int VEC_W      = 32;
    localparam int FACTOR_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // fraction bits dropped after each kind of product
    localparam int SCALE_FRAC = 8;
    localparam int MOVE_FRAC  = 16;
    localparam int TRIG_FRAC  = 14;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_Z = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPIN_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPIN_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPIN_Z = 3'd6;

    // register defaults: unit scale, no move, sin 0 and cos 1.0
    localparam logic [CFG_DATA_W-1:0] SCALE_RESET = 48'h0100_0100_0100;
    localparam logic [VEC_W-1:0]      MOVE_RESET  = 32'h0000_0000;
    localparam logic [VEC_W-1:0]      SPIN_RESET  = 32'h0000_4000;

    typedef logic signed [VEC_W-1:0]    t_vec;
    typedef logic signed [FACTOR_W-1:0] t_factor;
    typedef logic [CFG_IDX_W-1:0]       t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]      t_cfg_data;

endpackage

// ===== src/mvt_ifs.sv =====
interface mvt_vtx_if import mvt_pkg::*; ();
    logic valid;
    logic ready;
    t_vec in_x;
    t_vec in_y;
    t_vec in_z;
    t_vec in_w;
    logic is_normal;
    logic last_in_mesh;

    modport source (output valid, in_x, in_y, in_z, in_w, is_normal, last_in_mesh,
                    input ready);
    modport sink   (input valid, in_x, in_y, in_z, in_w, is_normal, last_in_mesh,
                    output ready);
    modport mon    (input valid, ready, in_x, in_y, in_z, in_w, is_normal,
                    last_in_mesh);
endinterface

interface mvt_res_if import mvt_pkg::*; ();
    logic valid;
    logic ready;
    t_vec out_x;
    t_vec out_y;
    t_vec out_z;
    t_vec out_w;
    logic last_out;

    modport source (output valid, out_x, out_y, out_z, out_w, last_out, input ready);
    modport sink   (input valid, out_x, out_y, out_z, out_w, last_out, output ready);
    modport mon    (input valid, ready, out_x, out_y, out_z, out_w, last_out);
endinterface

interface mvt_cfg_if import mvt_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
    modport mon    (input valid, ready, index, data);
endinterface

// ===== src/mesh_vertex_transform_core.sv =====
// an accepted vertex request passes through register stages 0 to 7 in order to its result on o_res
// throughput: one vertex per cycle while o_res does not stall, eight register stages, a multiply or an add in each
// a stalled output backs up stage by stage; empty stages still take requests
// reset (i_rst_n low at a clock edge) empties the pipeline and loads the
// registers with unit scale, zero move and zero-angle rotations
module mesh_vertex_transform_core import mvt_pkg::*; #(
    parameter int COORD_WIDTH = MVT_COORD_WIDTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mvt_vtx_if.sink      i_vtx,
    mvt_res_if.source    o_res,
    mvt_cfg_if.sink      i_cfg
);

    localparam int CW   = COORD_WIDTH;
    // product of a coordinate and a 16-bit factor
    localparam int PW   = COORD_WIDTH + FACTOR_W;
    // product of w and a move, kept down to the bits that survive the shift
    localparam int MW   = COORD_WIDTH + MOVE_FRAC;
    localparam int NSTG = 8;

    // ---------------------------------------------------------------
    // configuration registers, always ready
    // ---------------------------------------------------------------
    logic [CFG_DATA_W-1:0] r_scale;
    t_vec                  r_move_x, r_move_y, r_move_z;
    logic [VEC_W-1:0]      r_spin_x, r_spin_y, r_spin_z;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= SCALE_RESET;
            r_move_x <= MOVE_RESET;
            r_move_y <= MOVE_RESET;
            r_move_z <= MOVE_RESET;
            r_spin_x <= SPIN_RESET;
            r_spin_y <= SPIN_RESET;
            r_spin_z <= SPIN_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_SCALE:  r_scale  <= i_cfg.data;
                REG_MOVE_X: r_move_x <= i_cfg.data[VEC_W-1:0];
                REG_MOVE_Y: r_move_y <= i_cfg.data[VEC_W-1:0];
                REG_MOVE_Z: r_move_z <= i_cfg.data[VEC_W-1:0];
                REG_SPIN_X: r_spin_x <= i_cfg.data[VEC_W-1:0];
                REG_SPIN_Y: r_spin_y <= i_cfg.data[VEC_W-1:0];
                REG_SPIN_Z: r_spin_z <= i_cfg.data[VEC_W-1:0];
                default: ; // unmapped index, write dropped
            endcase
        end
    end

    // unpacked factors and trig values
    t_factor s_fx, s_fy, s_fz;
    t_factor s_sin_x, s_cos_x, s_sin_y, s_cos_y, s_sin_z, s_cos_z;

    assign s_fx    = r_scale[FACTOR_W-1:0];
    assign s_fy    = r_scale[2*FACTOR_W-1:FACTOR_W];
    assign s_fz    = r_scale[3*FACTOR_W-1:2*FACTOR_W];
    assign s_sin_x = r_spin_x[2*FACTOR_W-1:FACTOR_W];
    assign s_cos_x = r_spin_x[FACTOR_W-1:0];
    assign s_sin_y = r_spin_y[2*FACTOR_W-1:FACTOR_W];
    assign s_cos_y = r_spin_y[FACTOR_W-1:0];
    assign s_sin_z = r_spin_z[2*FACTOR_W-1:FACTOR_W];
    assign s_cos_z = r_spin_z[FACTOR_W-1:0];

    // ---------------------------------------------------------------
    // stage handshake: a stage loads when it is empty or drains onward
    // ---------------------------------------------------------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] s_adv;

    always_comb begin
        s_adv[NSTG-1] = !r_vld[NSTG-1] || o_res.ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            s_adv[i] = !r_vld[i] || s_adv[i+1];
        end
    end

    assign i_vtx.ready = s_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (s_adv[0]) begin
                r_vld[0] <= i_vtx.valid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (s_adv[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // w and the last-of-mesh flag ride alongside the datapath
    t_vec r_w    [NSTG];
    logic r_last [NSTG];

    always_ff @(posedge i_clk) begin
        if (s_adv[0]) begin
            r_w[0]    <= i_vtx.in_w;
            r_last[0] <= i_vtx.last_in_mesh;
        end
        for (int i = 1; i < NSTG; i++) begin
            if (s_adv[i]) begin
                r_w[i]    <= r_w[i-1];
                r_last[i] <= r_last[i-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // stage 0: scale products and w times move
    // ---------------------------------------------------------------
    logic signed [CW-1:0] n0_x, n0_y, n0_z;
    logic signed [PW-1:0] n0_px, n0_py, n0_pz;
    logic signed [MW-1:0] n0_mx, n0_my, n0_mz;

    // coordinates wrap (or sign-extend) to the datapath width on entry
    assign n0_x  = CW'(i_vtx.in_x);
    assign n0_y  = CW'(i_vtx.in_y);
    assign n0_z  = CW'(i_vtx.in_z);
    assign n0_px = PW'(n0_x) * PW'(s_fx);
    assign n0_py = PW'(n0_y) * PW'(s_fy);
    assign n0_pz = PW'(n0_z) * PW'(s_fz);
    assign n0_mx = MW'(i_vtx.in_w) * MW'(r_move_x);
    assign n0_my = MW'(i_vtx.in_w) * MW'(r_move_y);
    assign n0_mz = MW'(i_vtx.in_w) * MW'(r_move_z);

    logic signed [CW-1:0] r0_x, r0_y, r0_z;
    logic signed [PW-1:0] r0_px, r0_py, r0_pz;
    logic signed [MW-1:0] r0_mx, r0_my, r0_mz;
    logic                 r0_nrm;
    // sign of each factor for normals: zero and negative flags
    logic [2:0]           r0_fzero, r0_fneg;

    always_ff @(posedge i_clk) begin
        if (s_adv[0]) begin
            r0_x     <= n0_x;
            r0_y     <= n0_y;
            r0_z     <= n0_z;
            r0_px    <= n0_px;
            r0_py    <= n0_py;
            r0_pz    <= n0_pz;
            r0_mx    <= n0_mx;
            r0_my    <= n0_my;
            r0_mz    <= n0_mz;
            r0_nrm   <= i_vtx.is_normal;
            r0_fzero <= {s_fz == '0, s_fy == '0, s_fx == '0};
            r0_fneg  <= {s_fz[FACTOR_W-1], s_fy[FACTOR_W-1], s_fx[FACTOR_W-1]};
        end
    end

    // ---------------------------------------------------------------
    // stage 1: pick scaled value, add translation
    // ---------------------------------------------------------------
    logic signed [CW-1:0] n1_sx, n1_sy, n1_sz;
    logic signed [CW-1:0] n1_x, n1_y, n1_z;

    always_comb begin
        if (r0_nrm) begin
            n1_sx = r0_fzero[0] ? '0 : (r0_fneg[0] ? -r0_x : r0_x);
            n1_sy = r0_fzero[1] ? '0 : (r0_fneg[1] ? -r0_y : r0_y);
            n1_sz = r0_fzero[2] ? '0 : (r0_fneg[2] ? -r0_z : r0_z);
        end else begin
            n1_sx = r0_px[CW+SCALE_FRAC-1:SCALE_FRAC];
            n1_sy = r0_py[CW+SCALE_FRAC-1:SCALE_FRAC];
            n1_sz = r0_pz[CW+SCALE_FRAC-1:SCALE_FRAC];
        end
        n1_x = n1_sx + r0_mx[CW+MOVE_FRAC-1:MOVE_FRAC];
        n1_y = n1_sy + r0_my[CW+MOVE_FRAC-1:MOVE_FRAC];
        n1_z = n1_sz + r0_mz[CW+MOVE_FRAC-1:MOVE_FRAC];
    end

    logic signed [CW-1:0] r1_x, r1_y, r1_z;

    always_ff @(posedge i_clk) begin
        if (s_adv[1]) begin
            r1_x <= n1_x;
            r1_y <= n1_y;
            r1_z <= n1_z;
        end
    end

    // ---------------------------------------------------------------
    // stages 2 and 3: rotate about x
    // ---------------------------------------------------------------
    logic signed [PW-1:0] r2_yc, r2_zs, r2_ys, r2_zc;
    logic signed [CW-1:0] r2_x;

    always_ff @(posedge i_clk) begin
        if (s_adv[2]) begin
            r2_yc <= PW'(r1_y) * PW'(s_cos_x);
            r2_zs <= PW'(r1_z) * PW'(s_sin_x);
            r2_ys <= PW'(r1_y) * PW'(s_sin_x);
            r2_zc <= PW'(r1_z) * PW'(s_cos_x);
            r2_x  <= r1_x;
        end
    end

    logic signed [PW-1:0] n3_ya, n3_za;
    logic signed [CW-1:0] r3_x, r3_y, r3_z;

    assign n3_ya = r2_yc - r2_zs;
    assign n3_za = r2_ys + r2_zc;

    always_ff @(posedge i_clk) begin
        if (s_adv[3]) begin
            r3_x <= r2_x;
            r3_y <= n3_ya[CW+TRIG_FRAC-1:TRIG_FRAC];
            r3_z <= n3_za[CW+TRIG_FRAC-1:TRIG_FRAC];
        end
    end

    // ---------------------------------------------------------------
    // stages 4 and 5: rotate about y
    // ---------------------------------------------------------------
    logic signed [PW-1:0] r4_xc, r4_zs, r4_zc, r4_xs;
    logic signed [CW-1:0] r4_y;

    always_ff @(posedge i_clk) begin
        if (s_adv[4]) begin
            r4_xc <= PW'(r3_x) * PW'(s_cos_y);
            r4_zs <= PW'(r3_z) * PW'(s_sin_y);
            r4_zc <= PW'(r3_z) * PW'(s_cos_y);
            r4_xs <= PW'(r3_x) * PW'(s_sin_y);
            r4_y  <= r3_y;
        end
    end

    logic signed [PW-1:0] n5_xa, n5_za;
    logic signed [CW-1:0] r5_x, r5_y, r5_z;

    assign n5_xa = r4_xc + r4_zs;
    assign n5_za = r4_zc - r4_xs;

    always_ff @(posedge i_clk) begin
        if (s_adv[5]) begin
            r5_x <= n5_xa[CW+TRIG_FRAC-1:TRIG_FRAC];
            r5_y <= r4_y;
            r5_z <= n5_za[CW+TRIG_FRAC-1:TRIG_FRAC];
        end
    end

    // ---------------------------------------------------------------
    // stages 6 and 7: rotate about z, stage 7 is the output register
    // ---------------------------------------------------------------
    logic signed [PW-1:0] r6_xc, r6_ys, r6_xs, r6_yc;
    logic signed [CW-1:0] r6_z;

    always_ff @(posedge i_clk) begin
        if (s_adv[6]) begin
            r6_xc <= PW'(r5_x) * PW'(s_cos_z);
            r6_ys <= PW'(r5_y) * PW'(s_sin_z);
            r6_xs <= PW'(r5_x) * PW'(s_sin_z);
            r6_yc <= PW'(r5_y) * PW'(s_cos_z);
            r6_z  <= r5_z;
        end
    end

    logic signed [PW-1:0] n7_xa, n7_ya;
    logic signed [CW-1:0] n7_x, n7_y;
    t_vec                 r7_x, r7_y, r7_z;

    assign n7_xa = r6_xc - r6_ys;
    assign n7_ya = r6_xs + r6_yc;
    assign n7_x  = n7_xa[CW+TRIG_FRAC-1:TRIG_FRAC];
    assign n7_y  = n7_ya[CW+TRIG_FRAC-1:TRIG_FRAC];

    // results leave sign-extended (or cut) to the port width
    always_ff @(posedge i_clk) begin
        if (s_adv[7]) begin
            r7_x <= VEC_W'(n7_x);
            r7_y <= VEC_W'(n7_y);
            r7_z <= VEC_W'(r6_z);
        end
    end

    assign o_res.valid    = r_vld[NSTG-1];
    assign o_res.out_x    = r7_x;
    assign o_res.out_y    = r7_y;
    assign o_res.out_z    = r7_z;
    assign o_res.out_w    = r_w[NSTG-1];
    assign o_res.last_out = r_last[NSTG-1];

endmodule

// ===== src/mvt_checker.sv =====
module mvt_checker import mvt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_vtx_ready,
    input  logic i_res_valid,
    input  logic i_res_ready,
    input  t_vec i_res_x,
    input  t_vec i_res_y,
    input  t_vec i_res_z,
    input  t_vec i_res_w,
    input  logic i_res_last
);

    // pipeline empties on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result request valid right after reset");

    // a draining output leaves room at the input
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_ready |-> i_vtx_ready)
        else $error("input blocked while output drains");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("stalled result request dropped");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            $stable(i_res_x) && $stable(i_res_y) && $stable(i_res_z)
            && $stable(i_res_w) && $stable(i_res_last))
        else $error("stalled result request changed");

endmodule

bind mesh_vertex_transform_core mvt_checker u_mvt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_vtx_ready (i_vtx.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_x     (o_res.out_x),
    .i_res_y     (o_res.out_y),
    .i_res_z     (o_res.out_z),
    .i_res_w     (o_res.out_w),
    .i_res_last  (o_res.last_out)
);
